[rtl/lsc_pkg.sv]
`timescale 1ns / 1ps

package lsc_pkg;

    localparam logic [1:0] FUNC_CLEAR   = 2'd0;
    localparam logic [1:0] FUNC_WRITE   = 2'd1;
    localparam logic [1:0] FUNC_CONVERT = 2'd2;

    localparam int SAMPLE_W   = 32;
    localparam int FRAC_W     = 16;
    localparam int LOG_W      = 21;
    localparam int NORM_STEPS = 5;
    localparam int LAST_STEP  = NORM_STEPS + FRAC_W - 1;
    localparam int STEP_W     = 5;

    localparam int          LN2_W   = 24;
    localparam logic [23:0] LN2_Q24 = 24'd11629080;
    localparam int          PROD_W  = LOG_W + LN2_W;
    localparam int          T_W     = 56;
    localparam int          T_POS   = 40;
    localparam int          DIV_POS = 42;

    localparam int          RECIP_W   = 26;
    localparam int          DIV_SHIFT = 14;
    localparam logic [13:0] DIV_RECIP = 14'd5462;

    typedef struct packed {
        logic             done;
        logic [LOG_W-1:0] value;
    } t_log_out;

    function automatic longint lsc_part(longint u, longint a, longint b, longint rr);
        longint lo;
        longint span;
        lo   = a * rr;
        span = (b - a) * rr;
        if (u <= lo) begin
            return 0;
        end
        if (u - lo >= span) begin
            return span;
        end
        return u - lo;
    endfunction

endpackage

[rtl/lsc_log2.sv]
`timescale 1ns / 1ps

module lsc_log2
    import lsc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SAMPLE_W-1:0] i_value,
    output t_log_out            o_log
);

    logic [SAMPLE_W-1:0]   r_m;
    logic [SAMPLE_W-1:0]   n_m;
    logic [4:0]            r_e;
    logic [4:0]            n_e;
    logic [FRAC_W-1:0]     r_frac;
    logic [FRAC_W-1:0]     n_frac;
    logic [STEP_W-1:0]     r_step;
    logic                  r_busy;
    logic                  r_done;
    logic [4:0]            w_sh;
    logic [SAMPLE_W-1:0]   w_mask;
    logic [2*SAMPLE_W-1:0] w_sq;
    logic [SAMPLE_W:0]     w_m2;
    logic [STEP_W-1:0]     w_bit;

    assign w_sh   = 5'(5'd16 >> r_step[2:0]);
    assign w_mask = ~({SAMPLE_W{1'b1}} >> w_sh);
    assign w_sq   = 64'(r_m) * 64'(r_m);
    assign w_m2   = w_sq[2*SAMPLE_W-1:SAMPLE_W-1];
    assign w_bit  = STEP_W'(LAST_STEP) - r_step;

    always_comb begin
        n_m    = r_m;
        n_e    = r_e;
        n_frac = r_frac;
        if (r_step < STEP_W'(NORM_STEPS)) begin
            if ((r_m & w_mask) == '0) begin
                n_m = r_m << w_sh;
                n_e = r_e - w_sh;
            end
        end else if (w_m2[SAMPLE_W]) begin
            n_m = w_m2[SAMPLE_W:1];
            n_frac[w_bit[3:0]] = 1'b1;
        end else begin
            n_m = w_m2[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(LAST_STEP)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_m    <= i_value;
            r_e    <= 5'd31;
            r_frac <= '0;
        end else if (r_busy) begin
            r_m    <= n_m;
            r_e    <= n_e;
            r_frac <= n_frac;
        end
    end

    assign o_log.done  = r_done;
    assign o_log.value = {r_e, r_frac};

endmodule

[rtl/lsc_ramp.sv]
`timescale 1ns / 1ps

module lsc_ramp
    import lsc_pkg::*;
#(
    parameter int RAMP_ENTRIES = 512,
    parameter int IW           = $clog2(RAMP_ENTRIES)
) (
    input  logic          i_clk,
    input  logic [IW-1:0] i_idx,
    output logic [23:0]   o_rgb
);

    logic [23:0] w_ramp [RAMP_ENTRIES];
    logic [23:0] r_rgb;

    for (genvar gi = 0; gi < RAMP_ENTRIES; gi++) begin : g_ent
        localparam longint RR  = longint'(RAMP_ENTRIES);
        localparam longint U   = 200 * longint'(gi);
        localparam longint PR  = lsc_part(U, 25, 140, RR);
        localparam longint PG  = lsc_part(U, 120, 180, RR);
        localparam longint N1  = lsc_part(U, 150, 200, RR);
        localparam longint N2  = lsc_part(U, 0, 57, RR);
        localparam longint N3  = lsc_part(U, 63, 120, RR);
        localparam longint NB  = N1 * 114 + (N2 - N3) * 50;
        localparam longint RV  = 255 * PR / (115 * RR);
        localparam longint GV  = 255 * PG / (60 * RR);
        localparam longint BV  = 255 * NB / (5700 * RR);
        localparam longint RC  = (RV > 255) ? 255 : RV;
        localparam longint GC  = (GV > 255) ? 255 : GV;
        localparam longint BC  = (BV > 255) ? 255 : BV;
        assign w_ramp[gi] = {8'(RC), 8'(GC), 8'(BC)};
    end

    always_ff @(posedge i_clk) begin
        r_rgb <= w_ramp[i_idx];
    end

    assign o_rgb = r_rgb;

endmodule

[rtl/log_spectrogram_colormap_unit.sv]
`timescale 1ns / 1ps
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_ready    i_func i_column i_row i_sample
// output    out        o_out_valid / i_out_ready  o_red o_green o_blue o_byte_offset
//
// Clear, write and ignored requests complete when accepted; the unit stays idle.
// Convert runs a frame store read, 21 steps of the two log2 units (5 normalize,
// 16 squaring), the scale and divide stages, then one lookup; a zero sample or
// peak goes straight to the lookup, and the other early exits skip what remains.
// Reset (synchronous, active low) clears the peak and control; the store is not cleared.
// A result waiting in the output register stalls only the next convert at its lookup.

module log_spectrogram_colormap_unit
    import lsc_pkg::*;
#(
    parameter int COLS         = 256,
    parameter int ROWS         = 256,
    parameter int RAMP_ENTRIES = 512
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_func,
    input  logic [7:0]          i_column,
    input  logic [7:0]          i_row,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_red,
    output logic [7:0]          o_green,
    output logic [7:0]          o_blue,
    output logic [17:0]         o_byte_offset
);

    localparam int DEPTH = COLS * ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(RAMP_ENTRIES);
    localparam int QW    = $clog2(3 * RAMP_ENTRIES);
    localparam logic [T_W-1:0] FULL_T = (T_W'(RAMP_ENTRIES) * T_W'(12)) << T_POS;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_LOG   = 6'b000100,
        S_MUL   = 6'b001000,
        S_DIV   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [SAMPLE_W-1:0] r_peak;
    logic [SAMPLE_W-1:0] r_store [DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;
    logic [17:0]         r_off;
    logic [IW-1:0]       r_idx;
    logic [IW-1:0]       n_idx;
    logic [PROD_W-1:0]   r_prod;
    logic [PROD_W-1:0]   n_prod;
    logic [QW-1:0]       r_q;
    logic [QW-1:0]       n_q;
    logic                r_valid;
    logic                n_valid;
    logic                n_load;
    logic [7:0]          r_red;
    logic [7:0]          r_green;
    logic [7:0]          r_blue;
    logic [17:0]         r_out_off;

    logic                w_acc;
    logic                w_inrange;
    logic                w_wr;
    logic                w_rd;
    logic [19:0]         w_lin;
    logic [AW-1:0]       w_addr;
    logic [31:0]         w_off;
    logic                w_start;
    t_log_out            w_lp;
    t_log_out            w_ls;
    logic [LOG_W-1:0]    w_d;
    logic [T_W-1:0]      w_t;
    logic [RECIP_W-1:0]  w_qm;
    logic [RECIP_W-1:0]  w_div;
    logic [23:0]         w_rgb;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_inrange  = ({3'b0, i_column} < 11'(COLS)) && ({3'b0, i_row} < 11'(ROWS));
    assign w_wr       = w_acc && w_inrange && (i_func == FUNC_WRITE);
    assign w_rd       = w_acc && w_inrange && (i_func == FUNC_CONVERT);
    assign w_lin      = 20'(i_row) * 20'(COLS) + 20'(i_column);
    assign w_addr     = w_lin[AW-1:0];
    assign w_off      = ((32'(ROWS - 1) - 32'(i_row)) * 32'(COLS) + 32'(i_column)) * 32'd3;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_store[w_addr] <= i_sample;
        end
        if (w_rd) begin
            r_rdata <= r_store[w_addr];
        end
    end

    assign w_start = (r_state == S_START) && (r_rdata != '0) && (r_peak != '0);

    lsc_log2 u_log_peak (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_value (r_peak),
        .o_log   (w_lp)
    );

    lsc_log2 u_log_sample (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_value (r_rdata),
        .o_log   (w_ls)
    );

    lsc_ramp #(
        .RAMP_ENTRIES (RAMP_ENTRIES),
        .IW           (IW)
    ) u_ramp (
        .i_clk (i_clk),
        .i_idx (n_idx),
        .o_rgb (w_rgb)
    );

    assign w_d   = w_lp.value - w_ls.value;
    assign w_t   = T_W'(r_prod) * T_W'(RAMP_ENTRIES);
    assign w_qm  = RECIP_W'(r_q) * RECIP_W'(DIV_RECIP);
    assign w_div = w_qm >> DIV_SHIFT;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_prod  = r_prod;
        n_q     = r_q;
        n_valid = r_valid;
        n_load  = 1'b0;
        if (r_valid && i_out_ready) begin
            n_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_rd) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (w_start) begin
                    n_state = S_LOG;
                end else begin
                    n_idx   = '0;
                    n_state = S_OUT;
                end
            end
            S_LOG: begin
                if (w_lp.done) begin
                    if (w_lp.value <= w_ls.value) begin
                        n_idx   = IW'(RAMP_ENTRIES - 1);
                        n_state = S_OUT;
                    end else begin
                        n_prod  = PROD_W'(w_d) * PROD_W'(LN2_Q24);
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                if (w_t >= FULL_T) begin
                    n_idx   = '0;
                    n_state = S_OUT;
                end else begin
                    n_q     = QW'((FULL_T - w_t) >> DIV_POS);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div >= RECIP_W'(RAMP_ENTRIES)) begin
                    n_idx = IW'(RAMP_ENTRIES - 1);
                end else begin
                    n_idx = w_div[IW-1:0];
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_valid || i_out_ready) begin
                    n_load  = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_peak  <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (w_acc && (i_func == FUNC_CLEAR)) begin
                r_peak <= '0;
            end else if (w_wr && (i_sample > r_peak)) begin
                r_peak <= i_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_prod <= n_prod;
        r_q    <= n_q;
        if (w_rd) begin
            r_off <= w_off[17:0];
        end
        if (n_load) begin
            r_red     <= w_rgb[23:16];
            r_green   <= w_rgb[15:8];
            r_blue    <= w_rgb[7:0];
            r_out_off <= r_off;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_red         = r_red;
    assign o_green       = r_green;
    assign o_blue        = r_blue;
    assign o_byte_offset = r_out_off;

    a_log_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lp.done == w_ls.done)
        else $error("log2 units out of step");

    a_log_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lp.done |-> (r_state == S_LOG))
        else $error("log2 result outside log state");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result raised outside lookup state");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> ({1'b0, r_idx} < (IW + 1)'(RAMP_ENTRIES)))
        else $error("ramp index out of range");

    a_q_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ({1'b0, r_q} < (QW + 1)'(3 * RAMP_ENTRIES)))
        else $error("quotient input out of range");

endmodule
